@@ rtl/b2sbcd_pkg.sv @@
// Shared types, constants and helper functions for the binary to BCD converter.
package b2sbcd_pkg;

    localparam int DIGIT_COUNT_DEF = 8;
    localparam int DIGIT_COUNT_MAX = 10;
    localparam int VALUE_W         = 32;
    localparam int BCD_W           = 32;
    localparam int MASK_W          = 8;
    localparam int NIBBLE_W        = 4;
    localparam int PROD_W          = 64;
    localparam int RECIP_SHIFT     = 35;
    localparam int QUOT_W          = PROD_W - RECIP_SHIFT;

    // Reciprocal of ten scaled by 2^35; exact floor(v / 10) for any 32-bit v.
    localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new item and saturate it
        logic mul;       // form value times reciprocal of ten
        logic step;      // peel off one digit
        logic publish;   // copy the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic value_zero;
        logic pos_done;
    } t_sts;

    // Largest value that fits in the given number of decimal digits.
    function automatic logic [PROD_W-1:0] digit_limit(input int digits);
        logic [PROD_W-1:0] lim;
        lim = 64'd1;
        for (int k = 0; k < digits; k++) begin
            lim = lim * 64'd10;
        end
        return lim - 64'd1;
    endfunction

endpackage

@@ rtl/b2sbcd_ctrl.sv @@
// Controller state machine that sequences the digit-by-digit conversion.
module b2sbcd_ctrl
    import b2sbcd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIG  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                if (i_sts.value_zero || i_sts.pos_done) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = ST_DIG;
                end
            end
            ST_DIG: begin
                o_cmd.step = 1'b1;
                n_state    = ST_MUL;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/b2sbcd_dp.sv @@
// Datapath: saturation, reciprocal divide by ten, digit packing and output register.
module b2sbcd_dp
    import b2sbcd_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic [VALUE_W-1:0] i_value,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic [BCD_W-1:0]   o_bcd_digits,
    output logic [MASK_W-1:0]  o_digit_off_mask,
    output logic               o_overflow
);

    localparam int                POS_W = $clog2(DIGIT_COUNT + 1);
    localparam logic [PROD_W-1:0] LIMIT = digit_limit(DIGIT_COUNT);

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;
    logic [PROD_W-1:0]  r_prod;
    logic [BCD_W-1:0]   r_packed;
    logic [BCD_W-1:0]   n_packed;
    logic [MASK_W-1:0]  r_lit;
    logic [MASK_W-1:0]  n_lit;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   n_pos;
    logic               r_ovf;
    logic               n_ovf;
    logic [BCD_W-1:0]   r_bcd;
    logic [MASK_W-1:0]  r_mask;
    logic               r_ovf_out;

    logic               sat;
    logic [QUOT_W-1:0]  quot;
    logic [3:0]         quot10_lo;
    logic [3:0]         digit;
    logic [3:0]         pos_ext;

    assign sat       = {32'd0, i_value} > LIMIT;
    assign quot      = r_prod[PROD_W-1:RECIP_SHIFT];
    // Only the low nibble of value minus ten times quotient is needed.
    assign quot10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    assign digit     = r_value[3:0] - quot10_lo;
    assign pos_ext   = 4'(r_pos);

    assign o_sts.value_zero = (r_value == '0);
    assign o_sts.pos_done   = (r_pos == POS_W'(DIGIT_COUNT));

    always_comb begin
        n_value  = r_value;
        n_packed = r_packed;
        n_lit    = r_lit;
        n_pos    = r_pos;
        n_ovf    = r_ovf;
        if (i_cmd.load) begin
            n_value  = sat ? LIMIT[VALUE_W-1:0] : i_value;
            n_ovf    = sat;
            n_packed = '0;
            n_lit    = '0;
            n_pos    = '0;
        end else if (i_cmd.step) begin
            n_value = VALUE_W'(quot);
            n_pos   = r_pos + POS_W'(1);
            for (int i = 0; i < MASK_W; i++) begin
                if (pos_ext == 4'(i)) begin
                    n_packed[i*NIBBLE_W +: NIBBLE_W] = digit;
                    n_lit[i]                         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_packed <= n_packed;
        r_lit    <= n_lit;
        r_pos    <= n_pos;
        r_ovf    <= n_ovf;
        if (i_cmd.mul) begin
            r_prod <= r_value * RECIP_TEN;
        end
        if (i_cmd.publish) begin
            r_bcd     <= r_packed;
            r_mask    <= ~r_lit;
            r_ovf_out <= r_ovf;
        end
    end

    assign o_bcd_digits     = r_bcd;
    assign o_digit_off_mask = r_mask;
    assign o_overflow       = r_ovf_out;

endmodule

@@ rtl/binary_to_seven_segment_bcd.sv @@
// Top level of the binary to packed BCD converter for a seven-segment display.
//
// Usage: an item on the input channel carries one unsigned 32-bit value. It is
// accepted at a rising edge where i_valid is high and o_stall is low. The block
// holds one item at a time and raises o_stall from acceptance until the result
// has been moved into the output register.
// The result appears on o_bcd_digits, o_digit_off_mask and o_overflow with
// o_valid high, and is taken at an edge where o_valid is high and i_stall low.
// For each significant decimal digit (none for a value of zero, at most
// DIGIT_COUNT), the controller first issues the 32x32 reciprocal multiply by
// 1/10, which is registered, and then derives the quotient and the digit from
// it. Finally it sees the value run out or the digit count reached, and moves
// the result into the output register.
// A new item may be accepted in the cycle after the previous result has been
// placed in the output register.
// If the receiver stalls, the result holds steady and the finished next
// conversion waits inside until the output frees up.
// Synchronous active-low reset clears the controller and drops o_valid; the
// payload registers are not reset.
module binary_to_seven_segment_bcd
    import b2sbcd_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [BCD_W-1:0]   o_bcd_digits,
    output logic [MASK_W-1:0]  o_digit_off_mask,
    output logic               o_overflow
);

    // Commands flow from the controller, status flows back from the datapath.
    t_cmd cmd;
    t_sts sts;

    b2sbcd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // The datapath saturates the value, then divides by ten repeatedly,
    // packing one BCD nibble and one lit bit per significant digit.
    b2sbcd_dp #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_value          (i_value),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_bcd_digits     (o_bcd_digits),
        .o_digit_off_mask (o_digit_off_mask),
        .o_overflow       (o_overflow)
    );

endmodule

@@ verif/binary_to_seven_segment_bcd_check.sv @@
// Checker that predicts and compares every display word of the BCD converter.
module binary_to_seven_segment_bcd_check
    import b2sbcd_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_value_valid,
    input  logic               i_value_stall,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_result_valid,
    input  logic               i_result_stall,
    input  logic [BCD_W-1:0]   i_bcd_digits,
    input  logic [MASK_W-1:0]  i_digit_off_mask,
    input  logic               i_overflow,
    output int                 o_failures,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_saturated,
    output int                 o_blank
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BCD_W-1:0]  digits;
        logic [MASK_W-1:0] off_mask;
        logic              ovf;
    } t_display;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_display           want;
    } t_conversion;

    t_conversion conversions_in_flight [$];

    // Decimal split of one value, saturated to the largest number that fits.
    function automatic t_display predict_display(input logic [VALUE_W-1:0] value);
        t_display    res;
        logic [63:0] ceiling;
        logic [63:0] rest;
        logic [63:0] digit;
        ceiling = 64'd1;
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            ceiling = ceiling * 64'd10;
        end
        ceiling = ceiling - 64'd1;
        rest = {32'd0, value};
        res.digits = '0;
        res.off_mask = '1;
        res.ovf = 1'b0;
        if (rest > ceiling) begin
            rest = ceiling;
            res.ovf = 1'b1;
        end
        for (int pos = 0; pos < DIGIT_COUNT && rest != 64'd0; pos++) begin
            digit = rest % 64'd10;
            if (pos * NIBBLE_W < BCD_W) begin
                res.digits[pos*NIBBLE_W +: NIBBLE_W] = digit[NIBBLE_W-1:0];
            end
            if (pos < MASK_W) begin
                res.off_mask[pos] = 1'b0;
            end
            rest = rest / 64'd10;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_conversion oldest;
        t_display    got;
        t_conversion fresh;
        if (i_rst_n) begin
            if (i_result_valid && !i_result_stall) begin
                got.digits = i_bcd_digits;
                got.off_mask = i_digit_off_mask;
                got.ovf = i_overflow;
                o_results++;
                if (conversions_in_flight.size() == 0) begin
                    o_failures++;
                    if (o_failures <= 10) begin
                        $display("%0t: result %h/%h/%b arrived with no item outstanding",
                                 $realtime, got.digits, got.off_mask, got.ovf);
                    end
                end else begin
                    oldest = conversions_in_flight.pop_front();
                    if (oldest.want.ovf) o_saturated++;
                    if (oldest.value == '0) o_blank++;
                    if (got.digits !== oldest.want.digits ||
                        got.off_mask !== oldest.want.off_mask ||
                        got.ovf !== oldest.want.ovf) begin
                        o_failures++;
                        if (o_failures <= 10) begin
                            $display("%0t: value %0d expected bcd %h mask %h ovf %b, got %h %h %b",
                                     $realtime, oldest.value, oldest.want.digits,
                                     oldest.want.off_mask, oldest.want.ovf,
                                     got.digits, got.off_mask, got.ovf);
                        end
                    end
                end
            end
            if (i_value_valid && !i_value_stall) begin
                fresh.value = i_value;
                fresh.want = predict_display(i_value);
                conversions_in_flight.push_back(fresh);
            end
            o_pending = conversions_in_flight.size();
        end
    end

endmodule

@@ verif/binary_to_seven_segment_bcd_test.sv @@
// Top of the BCD converter testbench: clock, reset, stimulus and the final verdict.
module binary_to_seven_segment_bcd_test
    import b2sbcd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGITS       = DIGIT_COUNT_DEF;
    localparam int RANDOM_ITEMS = 1250;
    // Random items from CALM_FIRST up to but not including CALM_LAST are sent with no gaps and taken with no stalls.
    localparam int CALM_FIRST   = 300;
    localparam int CALM_LAST    = 450;
    // Once this many items have gone in, the receiver holds off for a long stretch.
    localparam int HOLD_AT      = 800;
    localparam int HOLD_CYCLES  = 250;
    // Extra wait after the last outstanding result has come out, to watch for stray results.
    localparam int DRAIN_CYCLES = 60;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [VALUE_W-1:0] i_value;
    logic               o_valid;
    logic               i_stall;
    logic [BCD_W-1:0]   o_bcd_digits;
    logic [MASK_W-1:0]  o_digit_off_mask;
    logic               o_overflow;

    int failures;
    int pending;
    int results;
    int saturated;
    int blank;

    // Shared between the sender and the receiver: the sender is the only writer.
    bit calm;
    int items_sent;

    logic [VALUE_W-1:0] corner_values [23];

    binary_to_seven_segment_bcd #(
        .DIGIT_COUNT(DIGITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_bcd_digits    (o_bcd_digits),
        .o_digit_off_mask(o_digit_off_mask),
        .o_overflow      (o_overflow)
    );

    binary_to_seven_segment_bcd_check #(
        .DIGIT_COUNT(DIGITS)
    ) check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_value_valid   (i_valid),
        .i_value_stall   (o_stall),
        .i_value         (i_value),
        .i_result_valid  (o_valid),
        .i_result_stall  (i_stall),
        .i_bcd_digits    (o_bcd_digits),
        .i_digit_off_mask(o_digit_off_mask),
        .i_overflow      (o_overflow),
        .o_failures      (failures),
        .o_pending       (pending),
        .o_results       (results),
        .o_saturated     (saturated),
        .o_blank         (blank)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Offers one item and returns at the edge where the block takes it. Before the
    // offer, valid may drop for a few random cycles so that gaps land on every phase
    // of a conversion. The payload stays put while the block stalls.
    task automatic offer_value(input logic [VALUE_W-1:0] v);
        while (!calm && $urandom_range(99) < 19) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        items_sent++;
    endtask

    // The receiver. It stalls at random, except in the calm stretch, and once holds
    // off for a long run of cycles while the sender keeps offering items. With one
    // result parked in the output register and one finished conversion waiting
    // behind it, the block has to stall its input during that hold.
    initial begin
        int  hold_left;
        bit  held;
        i_stall = 1'b0;
        hold_left = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && items_sent >= HOLD_AT) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (calm) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 19);
            end
        end
    end

    // The sender. Directed corners come first: zero, the edges of every digit
    // count, the saturation boundary, all-ones and alternating bit patterns, and
    // a value with zeros between lit digits. Random items then pick a digit count
    // evenly so that each mask shape shows up often, with a share of raw 32-bit
    // words and of values above eight digits to exercise saturation.
    initial begin
        int                 pick;
        int                 width;
        logic [63:0]        span_low;
        logic [VALUE_W-1:0] v;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        calm = 1'b0;
        items_sent = 0;
        corner_values = '{
            32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
            32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999, 32'd1000000,
            32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000,
            32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd50607080
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (corner_values[i]) begin
            offer_value(corner_values[i]);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= CALM_FIRST && n < CALM_LAST);
            pick = $urandom_range(99);
            if (pick < 12) begin
                v = $urandom();
            end else if (pick < 20) begin
                // Anything past eight digits saturates.
                v = $urandom_range(32'hFFFF_FFFF, 32'd100000000);
            end else begin
                width = $urandom_range(DIGITS, 0);
                if (width == 0) begin
                    v = '0;
                end else begin
                    span_low = 64'd1;
                    repeat (width - 1) span_low = span_low * 64'd10;
                    v = $urandom_range(32'(span_low * 64'd10 - 64'd1), 32'(span_low));
                end
            end
            offer_value(v);
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        // Let every outstanding result drain, then watch a while longer for strays.
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d conversions (%0d saturated, %0d blank) under random gaps,",
                 results, saturated, blank);
        $display("random output stalls and one %0d-cycle output hold-off.", HOLD_CYCLES);
        if (failures == 0 && pending == 0) begin
            $display("binary_to_seven_segment_bcd_test passed");
        end else begin
            $display("binary_to_seven_segment_bcd_test failed");
        end
        $finish;
    end

    // A correct run finishes well before this timeout; reaching it means something hung.
    initial begin
        #2000000;
        $display("Timed out with %0d results still outstanding.", pending);
        $display("binary_to_seven_segment_bcd_test failed");
        $finish;
    end

endmodule
